[rtl/spn_pkg.sv]
// spn_pkg: constants, register indexes and round functions of the 16-bit spn cipher
// shared by the cipher pipeline; depends on nothing

package spn_pkg;

  localparam int unsigned BlockW      = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned RoundsDef   = 4;
  localparam int unsigned RoundsMax   = 8;
  localparam logic [KeyW-1:0] KeyRst  = 32'hC001_CA75;
  localparam logic            MixRst  = 1'b1;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [KeyW-1:0]   key_t;

  typedef enum logic [0:0] {
    CfgKey = 1'b0,
    CfgMix = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MixBits   = 1'b0,
    MixMatrix = 1'b1
  } mix_mode_e;

  function automatic logic [3:0] sbox(input logic [3:0] a);
    logic [3:0] y;
    unique case (a)
      4'h0: y = 4'h0;
      4'h1: y = 4'h3;
      4'h2: y = 4'h5;
      4'h3: y = 4'h8;
      4'h4: y = 4'h6;
      4'h5: y = 4'hC;
      4'h6: y = 4'hB;
      4'h7: y = 4'h7;
      4'h8: y = 4'hA;
      4'h9: y = 4'h4;
      4'hA: y = 4'h9;
      4'hB: y = 4'hE;
      4'hC: y = 4'hF;
      4'hD: y = 4'h1;
      4'hE: y = 4'h2;
      default: y = 4'hD;
    endcase
    return y;
  endfunction

  function automatic block_t sub_layer(input block_t x);
    return {sbox(x[15:12]), sbox(x[11:8]), sbox(x[7:4]), sbox(x[3:0])};
  endfunction

  // fixed bit transposition
  function automatic block_t bit_mix(input block_t x);
    block_t y;
    y = x & 16'h8421;
    y = y ^ ((x & 16'h0842) << 3);
    y = y ^ ((x & 16'h0084) << 6);
    y = y ^ ((x & 16'h0008) << 9);
    y = y ^ ((x & 16'h1000) >> 9);
    y = y ^ ((x & 16'h2100) >> 6);
    y = y ^ ((x & 16'h4210) >> 3);
    return y;
  endfunction

  // multiply by x in gf(2^4) mod x^4+x+1
  function automatic logic [3:0] gf_dbl(input logic [3:0] a);
    return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic logic [3:0] gf_trp(input logic [3:0] a);
    return gf_dbl(a) ^ a;
  endfunction

  function automatic block_t matrix_mix(input block_t x);
    logic [3:0] a0, a1, a2, a3, b0, b1, b2, b3;
    a0 = x[15:12];
    a1 = x[11:8];
    a2 = x[7:4];
    a3 = x[3:0];
    b0 = gf_dbl(a0) ^ gf_trp(a1) ^ a2 ^ a3;
    b1 = a0 ^ gf_dbl(a1) ^ gf_trp(a2) ^ a3;
    b2 = a0 ^ a1 ^ gf_dbl(a2) ^ gf_trp(a3);
    b3 = gf_trp(a0) ^ a1 ^ a2 ^ gf_dbl(a3);
    return {b0, b1, b2, b3};
  endfunction

  // round key i: low half of the key rotated right by 4*i
  function automatic block_t round_key(input key_t k, input int unsigned i);
    logic [2*KeyW-1:0] kk;
    kk = {k, k} >> (4 * i);
    return kk[BlockW-1:0];
  endfunction

endpackage

[rtl/spn_block_encrypt_16bit_unit.sv]
// spn_block_encrypt_16bit_unit: fully unrolled, pipelined 16-bit spn block cipher
// uses spn_pkg for the s-box, mixing layers and round key derivation
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, plaintext_i       | word in
//   out     | out_valid_o, out_stall_i, ciphertext_o    | word out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i          | reg write
//
// one word per cycle while out_stall_i is low; one register stage per round
// plus the whitening stage at the input
// out_stall_i freezes only the stages that are full, bubbles still close up
// reset empties the pipeline and loads key 0xC001CA75 and matrix mixing

module spn_block_encrypt_16bit_unit #(
  parameter int unsigned Rounds = spn_pkg::RoundsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [spn_pkg::BlockW-1:0]    plaintext_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spn_pkg::BlockW-1:0]    ciphertext_o,
  input  logic                          cfg_we_i,
  input  spn_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [spn_pkg::KeyW-1:0]      cfg_wdata_i
);
  import spn_pkg::*;

  localparam int unsigned NumStages = Rounds + 1;
  localparam int unsigned Last      = NumStages - 1;

  key_t      cipher_key_q;
  mix_mode_e mix_mode_q;

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;
  block_t               data_q [NumStages];
  block_t               data_d [NumStages];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q <= KeyRst;
      mix_mode_q   <= mix_mode_e'(MixRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKey: cipher_key_q <= cfg_wdata_i;
        CfgMix: mix_mode_q   <= mix_mode_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its word moves on
  always_comb begin
    ready[NumStages] = !out_stall_i;
    for (int s = Last; s >= 0; s--) begin
      ready[s] = !valid_q[s] || ready[s+1];
    end
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    if (s == 0) begin : g_white
      assign data_d[s] = plaintext_i ^ round_key(cipher_key_q, 0);
    end else if (s == Last) begin : g_final
      assign data_d[s] = sub_layer(data_q[s-1]) ^ round_key(cipher_key_q, s);
    end else begin : g_round
      block_t sub;
      assign sub       = sub_layer(data_q[s-1]);
      assign data_d[s] = ((mix_mode_q == MixMatrix) ? matrix_mix(sub) : bit_mix(sub))
                         ^ round_key(cipher_key_q, s);
    end

    logic up_valid;
    if (s == 0) begin : g_vin
      assign up_valid = in_valid_i;
    end else begin : g_vpipe
      assign up_valid = valid_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ready[s]) begin
        valid_q[s] <= up_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[s] && up_valid) begin
        data_q[s] <= data_d[s];
      end
    end
  end

  assign in_stall_o   = !ready[0];
  assign out_valid_o  = valid_q[Last];
  assign ciphertext_o = data_q[Last];

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted word did not enter the first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> valid_q[0])
    else $error("input stalled with an empty first stage");

  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output side is free");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(valid_q[Last]) |-> $past(!out_stall_i))
    else $error("output word vanished without delivery");

endmodule
